// ===== sv/gpio_bank_with_pin_interrupts_macros.svh =====
// Assertion macros for the GPIO bank RTL, included by gbpi_core.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef GPIO_BANK_WITH_PIN_INTERRUPTS_MACROS_SVH
`define GPIO_BANK_WITH_PIN_INTERRUPTS_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define GBPI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define GBPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gbpi_pkg.sv =====
// Shared types and constants for the GPIO bank with pin interrupts.
// No dependencies; every other file except the assertion macro header imports this package.
package gbpi_pkg;

  // Command codes
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_WRITE  = 2'd2;

  // Register word indexes
  localparam logic [3:0] ADDR_ID        = 4'd0;
  localparam logic [3:0] ADDR_IN        = 4'd1;
  localparam logic [3:0] ADDR_OUT       = 4'd2;
  localparam logic [3:0] ADDR_DIR       = 4'd3;
  localparam logic [3:0] ADDR_HIGH_PEND = 4'd4;
  localparam logic [3:0] ADDR_HIGH_EN   = 4'd5;
  localparam logic [3:0] ADDR_LOW_PEND  = 4'd6;
  localparam logic [3:0] ADDR_LOW_EN    = 4'd7;
  localparam logic [3:0] ADDR_RISE_PEND = 4'd8;
  localparam logic [3:0] ADDR_RISE_EN   = 4'd9;
  localparam logic [3:0] ADDR_FALL_PEND = 4'd10;
  localparam logic [3:0] ADDR_FALL_EN   = 4'd11;

  // Event classes, index into the pending/enable pairs
  localparam int EV_HIGH = 0;
  localparam int EV_LOW  = 1;
  localparam int EV_RISE = 2;
  localparam int EV_FALL = 3;
  localparam int EV_NUM  = 4;

  // Upper half of the id word: number of banks
  localparam logic [15:0] ID_BANKS = 16'd1;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int ADDR_W = 4;
  localparam int WORD_W = 32;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] pins_in;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [WORD_W-1:0] pins_out;
    logic [WORD_W-1:0] pins_drive;
    logic              irq;
  } rsp_t;

endpackage

// ===== sv/gbpi_intf.sv =====
// Valid/ready channel interfaces for the GPIO bank request and result.
// Depends on gbpi_pkg for field widths.
interface gbpi_req_if;
  import gbpi_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;
  logic [WORD_W-1:0] write_data;
  logic [WORD_W-1:0] pins_in;

  modport source (output valid, command, address, write_data, pins_in, input ready);
  modport sink   (input valid, command, address, write_data, pins_in, output ready);
endinterface

interface gbpi_rsp_if;
  import gbpi_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_data;
  logic [WORD_W-1:0] pins_out;
  logic [WORD_W-1:0] pins_drive;
  logic              irq;

  modport source (output valid, read_data, pins_out, pins_drive, irq, input ready);
  modport sink   (input valid, read_data, pins_out, pins_drive, irq, output ready);
endinterface

// ===== sv/gbpi_in_stage.sv =====
// Input register of the GPIO bank: holds one request transaction.
// Depends on gbpi_pkg (req_t).
module gbpi_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gbpi_pkg::req_t in_req,
  input  logic          adv,
  output logic          fire,
  output gbpi_pkg::req_t req
);
  import gbpi_pkg::*;

  logic valid_r, valid_nxt;
  req_t req_r;

  // Slot is free when empty or when the held request moves on this cycle
  assign in_ready = !valid_r || adv;
  assign fire     = valid_r && adv;
  assign req      = req_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_req;
    end
  end
endmodule

// ===== sv/gbpi_core.sv =====
// Register file, event detection and read mux of the GPIO bank.
// Depends on gbpi_pkg and the assertion macro header.
module gbpi_core #(
  parameter int PIN_COUNT = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  gbpi_pkg::req_t req,
  output gbpi_pkg::rsp_t rsp
);
  import gbpi_pkg::*;
  `include "gpio_bank_with_pin_interrupts_macros.svh"

  localparam int P = PIN_COUNT;

  logic [P-1:0] out_latch_r, out_latch_nxt;
  logic [P-1:0] dir_r, dir_nxt;
  logic [P-1:0] prev_r, prev_nxt;
  logic [P-1:0] en_r [EV_NUM];
  logic [P-1:0] en_nxt [EV_NUM];
  logic [P-1:0] pend_r [EV_NUM];
  logic [P-1:0] pend_nxt [EV_NUM];
  logic [P-1:0] clr [EV_NUM];
  logic [P-1:0] ev [EV_NUM];
  logic [P-1:0] wd, pins, pend_any;
  logic [WORD_W-1:0] rd_word;
  logic is_wr;

  // Unused pins drop out by truncation to P bits
  assign wd    = req.write_data[P-1:0];
  assign pins  = req.pins_in[P-1:0];
  assign is_wr = (req.command == CMD_WRITE);

  // Events, judged with the enables held before this transaction
  always_comb begin
    ev[EV_HIGH] = pins & en_r[EV_HIGH];
    ev[EV_LOW]  = ~pins & en_r[EV_LOW];
    ev[EV_RISE] = pins & ~prev_r & en_r[EV_RISE];
    ev[EV_FALL] = ~pins & prev_r & en_r[EV_FALL];
  end

  // Read mux on the pre-transaction register contents
  always_comb begin
    rd_word = '0;
    if (req.command == CMD_READ) begin
      unique case (req.address)
        ADDR_ID:        rd_word = {ID_BANKS, 16'(P)};
        ADDR_IN:        rd_word = WORD_W'(pins);
        ADDR_OUT:       rd_word = WORD_W'(out_latch_r);
        ADDR_DIR:       rd_word = WORD_W'(dir_r);
        ADDR_HIGH_PEND: rd_word = WORD_W'(pend_r[EV_HIGH]);
        ADDR_HIGH_EN:   rd_word = WORD_W'(en_r[EV_HIGH]);
        ADDR_LOW_PEND:  rd_word = WORD_W'(pend_r[EV_LOW]);
        ADDR_LOW_EN:    rd_word = WORD_W'(en_r[EV_LOW]);
        ADDR_RISE_PEND: rd_word = WORD_W'(pend_r[EV_RISE]);
        ADDR_RISE_EN:   rd_word = WORD_W'(en_r[EV_RISE]);
        ADDR_FALL_PEND: rd_word = WORD_W'(pend_r[EV_FALL]);
        ADDR_FALL_EN:   rd_word = WORD_W'(en_r[EV_FALL]);
        default:        rd_word = '0;
      endcase
    end
  end

  // Register writes and pending update; new events win over a clear
  always_comb begin
    out_latch_nxt = out_latch_r;
    dir_nxt       = dir_r;
    prev_nxt      = prev_r;
    for (int i = 0; i < EV_NUM; i++) begin
      en_nxt[i]   = en_r[i];
      clr[i]      = '0;
      pend_nxt[i] = pend_r[i];
    end
    if (fire) begin
      prev_nxt = pins;
      if (is_wr) begin
        unique case (req.address)
          ADDR_OUT:       out_latch_nxt   = wd;
          ADDR_DIR:       dir_nxt         = wd;
          ADDR_HIGH_PEND: clr[EV_HIGH]    = wd;
          ADDR_HIGH_EN:   en_nxt[EV_HIGH] = wd;
          ADDR_LOW_PEND:  clr[EV_LOW]     = wd;
          ADDR_LOW_EN:    en_nxt[EV_LOW]  = wd;
          ADDR_RISE_PEND: clr[EV_RISE]    = wd;
          ADDR_RISE_EN:   en_nxt[EV_RISE] = wd;
          ADDR_FALL_PEND: clr[EV_FALL]    = wd;
          ADDR_FALL_EN:   en_nxt[EV_FALL] = wd;
          default:        ;
        endcase
      end
      for (int i = 0; i < EV_NUM; i++) begin
        pend_nxt[i] = (pend_r[i] & ~clr[i]) | ev[i];
      end
    end
  end

  assign pend_any = pend_nxt[EV_HIGH] | pend_nxt[EV_LOW] | pend_nxt[EV_RISE] | pend_nxt[EV_FALL];

  // Pin and irq outputs reflect state after this transaction; read data shows the state before it
  always_comb begin
    rsp.read_data  = rd_word;
    rsp.pins_out   = WORD_W'(out_latch_nxt);
    rsp.pins_drive = WORD_W'(dir_nxt);
    rsp.irq        = |pend_any;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_latch_r <= '0;
      dir_r       <= '0;
      prev_r      <= '0;
      for (int i = 0; i < EV_NUM; i++) begin
        en_r[i]   <= '0;
        pend_r[i] <= '0;
      end
    end else begin
      out_latch_r <= out_latch_nxt;
      dir_r       <= dir_nxt;
      prev_r      <= prev_nxt;
      for (int i = 0; i < EV_NUM; i++) begin
        en_r[i]   <= en_nxt[i];
        pend_r[i] <= pend_nxt[i];
      end
    end
  end

  // A high-level event must leave its pending bits set even under a clear
  `GBPI_ASSERT_NEXT(a_high_evt_sticks, fire && (ev[EV_HIGH] != '0), (pend_r[EV_HIGH] & $past(ev[EV_HIGH])) == $past(ev[EV_HIGH]), "high event lost")
  // State only moves when a transaction is processed
  `GBPI_ASSERT_NEXT(a_idle_holds, !fire, $stable(out_latch_r) && $stable(dir_r) && $stable(prev_r), "state changed while idle")
  // Direction write lands on the next cycle
  `GBPI_ASSERT_NEXT(a_dir_write, fire && is_wr && (req.address == ADDR_DIR), dir_r == $past(wd), "direction write lost")
  // Reads return zero on anything but a read command
  `GBPI_ASSERT_NOW(a_rd_zero, req.command != CMD_READ, rd_word == '0, "read data without read")
endmodule

// ===== sv/gbpi_out_stage.sv =====
// Result register of the GPIO bank: holds one result transaction.
// Depends on gbpi_pkg (rsp_t).
module gbpi_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  gbpi_pkg::rsp_t rsp,
  output logic           adv,
  output logic           out_valid,
  input  logic           out_ready,
  output gbpi_pkg::rsp_t out_rsp
);
  import gbpi_pkg::*;

  logic valid_r, valid_nxt;
  rsp_t rsp_r;

  // Register can take a new result when empty or being drained
  assign adv       = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

  always_comb begin
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_r <= rsp;
    end
  end
endmodule

// ===== sv/gpio_bank_with_pin_interrupts.sv =====
// Top level of the PIN_COUNT-pin (32 by default) GPIO bank with level and edge pin interrupts.
// Depends on gbpi_pkg, gbpi_intf, gbpi_in_stage, gbpi_core, gbpi_out_stage.
//
//   Channel  | Direction | Payload                                  | Handshake
//   in_req   | sink      | command, address, write_data, pins_in    | valid/ready
//   out_rsp  | source    | read_data, pins_out, pins_drive, irq     | valid/ready
//
// One transaction per clock sustained while the result is not stalled; a result passes
// through the input register, then the result register loaded with the register-file update.
// Reset (rst_n low, synchronous) clears latch, direction, enables, pending and
// previous-pin state, and empties both registers.
// A stalled result holds the pipeline; the input register still takes a
// transaction whenever the result register drains in the same cycle.
module gpio_bank_with_pin_interrupts #(
  parameter int PIN_COUNT = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  gbpi_req_if.sink   in_req,
  gbpi_rsp_if.source out_rsp
);
  import gbpi_pkg::*;

  req_t in_pay, req;
  rsp_t rsp, out_pay;
  logic fire, adv;

  assign in_pay.command    = in_req.command;
  assign in_pay.address    = in_req.address;
  assign in_pay.write_data = in_req.write_data;
  assign in_pay.pins_in    = in_req.pins_in;

  gbpi_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .in_req   (in_pay),
    .adv      (adv),
    .fire     (fire),
    .req      (req)
  );

  gbpi_core #(.PIN_COUNT(PIN_COUNT)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (req),
    .rsp   (rsp)
  );

  gbpi_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .rsp       (rsp),
    .adv       (adv),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .out_rsp   (out_pay)
  );

  assign out_rsp.read_data  = out_pay.read_data;
  assign out_rsp.pins_out   = out_pay.pins_out;
  assign out_rsp.pins_drive = out_pay.pins_drive;
  assign out_rsp.irq        = out_pay.irq;
endmodule
